@@ hw/rtl/tile_image_transform_engine_defines.svh @@
// assertion macros used by the checker file titr_checker.sv
// no dependencies; expects clk_i and rst_ni in the using scope
`ifndef TILE_IMAGE_TRANSFORM_ENGINE_DEFINES_SVH
`define TILE_IMAGE_TRANSFORM_ENGINE_DEFINES_SVH

// same-cycle implication
`define TITR_ASSERT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("titr assertion failed");

// next-cycle implication
`define TITR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("titr assertion failed");

`endif

@@ hw/rtl/titr_pkg.sv @@
// shared types, constants and helper functions of the image transform engine
// no dependencies
package titr_pkg;

  localparam int DIM   = 32;
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DIM + 1);
  localparam int LW    = (CW > 4) ? CW : 4;
  localparam int SW    = 9;
  localparam int KW    = 4;
  localparam int ARGW  = 7;
  localparam int PIXW  = 8;
  localparam int CNTW  = 7;

  typedef enum logic [KW-1:0] {
    K_SIZE       = 4'd0,
    K_WRITE      = 4'd1,
    K_READ       = 4'd2,
    K_SWAPCELL   = 4'd3,
    K_SWAPROWS   = 4'd4,
    K_SWAPCOLS   = 4'd5,
    K_SWAPDIAG   = 4'd6,
    K_REVROW     = 4'd7,
    K_REVCOL     = 4'd8,
    K_REVDIAG    = 4'd9,
    K_MIRRORROWS = 4'd10,
    K_MIRRORCOLS = 4'd11,
    K_ROTATE     = 4'd12,
    K_SWAPNEIGH  = 4'd13,
    K_TRANSPOSE  = 4'd14
  } kind_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_GEN, S_RD1, S_RD2, S_WR1, S_WR2,
    S_PIXW, S_PIXR, S_PIXL, S_CPY, S_MAP, S_DONE
  } state_e;

  typedef struct packed {
    kind_e                kind;
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] c;
    logic signed [SW-1:0] d;
  } cmd_t;

  typedef struct packed {
    logic [AW-1:0] addr1;
    logic [AW-1:0] addr2;
    logic          do_pair;
  } pair_t;

  // neighbourhood offsets (row, column)
  localparam logic signed [1:0] NBR_DR [8] =
    '{2'sb11, 2'sb11, 2'sb11, 2'sb00, 2'sb00, 2'sb01, 2'sb01, 2'sb01};
  localparam logic signed [1:0] NBR_DC [8] =
    '{2'sb11, 2'sb00, 2'sb01, 2'sb11, 2'sb01, 2'sb11, 2'sb00, 2'sb01};

  function automatic logic cell_in(logic signed [SW-1:0] r, logic signed [SW-1:0] c,
                                   logic [CW-1:0] rows, logic [CW-1:0] cols);
    logic signed [SW-1:0] rs;
    logic signed [SW-1:0] cs;
    rs = signed'(SW'(rows));
    cs = signed'(SW'(cols));
    return (r >= 0) && (r < rs) && (c >= 0) && (c < cs);
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic signed [SW-1:0] r,
                                              logic signed [SW-1:0] c);
    return AW'(AW'(r) * AW'(DIM) + AW'(c));
  endfunction

endpackage

@@ hw/rtl/titr_cmd_if.sv @@
// command channel of the image transform engine
// depends on titr_pkg
interface titr_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [titr_pkg::KW-1:0]             kind;
  logic signed [titr_pkg::ARGW-1:0]    arg_a;
  logic signed [titr_pkg::ARGW-1:0]    arg_b;
  logic signed [titr_pkg::ARGW-1:0]    arg_c;
  logic signed [titr_pkg::ARGW-1:0]    arg_d;
  logic [titr_pkg::PIXW-1:0]           pixel_in;

  modport source (output valid, kind, arg_a, arg_b, arg_c, arg_d, pixel_in, input ready);
  modport sink   (input valid, kind, arg_a, arg_b, arg_c, arg_d, pixel_in, output ready);
endinterface

@@ hw/rtl/titr_res_if.sv @@
// result channel of the image transform engine
// depends on titr_pkg
interface titr_res_if;
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic [titr_pkg::PIXW-1:0] pixel_out;
  logic [titr_pkg::CNTW-1:0] row_count;
  logic [titr_pkg::CNTW-1:0] col_count;

  modport source (output valid, ok, pixel_out, row_count, col_count, input ready);
  modport sink   (input valid, ok, pixel_out, row_count, col_count, output ready);
endinterface

@@ hw/rtl/titr_ram.sv @@
// generic single-port ram with registered read
// no dependencies
module titr_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end
endmodule

@@ hw/rtl/titr_pairgen.sv @@
// cell pair generator: maps command and loop counters to two cell addresses
// depends on titr_pkg
module titr_pairgen (
  input  titr_pkg::cmd_t          cmd_i,
  input  logic [titr_pkg::CW-1:0] rows_i,
  input  logic [titr_pkg::CW-1:0] cols_i,
  input  logic [titr_pkg::LW-1:0] i_i,
  input  logic [titr_pkg::LW-1:0] j_i,
  output titr_pkg::pair_t         pair_o
);
  logic signed [titr_pkg::SW-1:0] ii, jj, rs, cs, m, dr, dc;
  logic signed [titr_pkg::SW-1:0] r1, c1, r2, c2;

  assign ii = signed'(titr_pkg::SW'(i_i));
  assign jj = signed'(titr_pkg::SW'(j_i));
  assign rs = signed'(titr_pkg::SW'(rows_i));
  assign cs = signed'(titr_pkg::SW'(cols_i));
  assign m  = cmd_i.a[titr_pkg::SW-1] ? -cmd_i.a : cmd_i.a;
  assign dr = titr_pkg::SW'(titr_pkg::NBR_DR[j_i[2:0]]);
  assign dc = titr_pkg::SW'(titr_pkg::NBR_DC[j_i[2:0]]);

  // coordinates of the two cells of the current step
  always_comb begin
    r1 = '0; c1 = '0; r2 = '0; c2 = '0;
    unique case (cmd_i.kind)
      titr_pkg::K_WRITE, titr_pkg::K_READ: begin
        r1 = cmd_i.a; c1 = cmd_i.b; r2 = cmd_i.a; c2 = cmd_i.b;
      end
      titr_pkg::K_SWAPCELL: begin
        r1 = cmd_i.a; c1 = cmd_i.b; r2 = cmd_i.c; c2 = cmd_i.d;
      end
      titr_pkg::K_SWAPROWS: begin
        r1 = cmd_i.a; c1 = jj; r2 = cmd_i.b; c2 = jj;
      end
      titr_pkg::K_SWAPCOLS: begin
        r1 = jj; c1 = cmd_i.a; r2 = jj; c2 = cmd_i.b;
      end
      titr_pkg::K_SWAPDIAG: begin
        r1 = cmd_i.a + jj; c1 = jj; r2 = jj; c2 = cmd_i.a + jj;
      end
      titr_pkg::K_REVROW: begin
        r1 = cmd_i.a; c1 = jj; r2 = cmd_i.a; c2 = cs - 1 - jj;
      end
      titr_pkg::K_REVCOL: begin
        r1 = jj; c1 = cmd_i.a; r2 = rs - 1 - jj; c2 = cmd_i.a;
      end
      titr_pkg::K_REVDIAG: begin
        if (!cmd_i.a[titr_pkg::SW-1]) begin
          r1 = jj; c1 = m + jj; r2 = rs - 1 - jj - m; c2 = rs - 1 - jj;
        end else begin
          r1 = m + jj; c1 = jj; r2 = rs - 1 - jj; c2 = rs - 1 - jj - m;
        end
      end
      titr_pkg::K_MIRRORROWS: begin
        r1 = ii; c1 = jj; r2 = ii; c2 = cs - 1 - jj;
      end
      titr_pkg::K_MIRRORCOLS: begin
        r1 = jj; c1 = ii; r2 = rs - 1 - jj; c2 = ii;
      end
      titr_pkg::K_SWAPNEIGH: begin
        r1 = cmd_i.a + dr; c1 = cmd_i.b + dc; r2 = cmd_i.c + dr; c2 = cmd_i.d + dc;
      end
      // source in scratch, destination in store
      titr_pkg::K_ROTATE: begin
        r1 = ii; c1 = jj; r2 = jj; c2 = rs - 1 - ii;
      end
      titr_pkg::K_TRANSPOSE: begin
        r1 = jj; c1 = ii; r2 = ii; c2 = jj;
      end
      default: begin
        r1 = '0; c1 = '0; r2 = '0; c2 = '0;
      end
    endcase
  end

  assign pair_o.addr1   = titr_pkg::cell_addr(r1, c1);
  assign pair_o.addr2   = titr_pkg::cell_addr(r2, c2);
  assign pair_o.do_pair = (cmd_i.kind == titr_pkg::K_ROTATE) ||
                          (cmd_i.kind == titr_pkg::K_TRANSPOSE) ||
                          (titr_pkg::cell_in(r1, c1, rows_i, cols_i) &&
                           titr_pkg::cell_in(r2, c2, rows_i, cols_i));
endmodule

@@ hw/rtl/tile_image_transform_engine.sv @@
// image transform engine: pixel matrix with swap, reverse, rotate, transpose
// depends on titr_pkg, titr_cmd_if, titr_res_if, titr_ram, titr_pairgen
//
// usage: one command transfer on cmd_i gives exactly one result transfer on
// res_o (ok flag, pixel read, row and column counts after the command).
// cmd_i.ready is high only while the sequencer is idle; one command is worked
// at a time through a single-port pixel store and a single-port scratch ram.
// swaps and reversals step over cell pairs and skip out-of-range steps; rotate
// and transpose first copy the store to scratch, then remap into the store.
// each swap costs one read and one write per cell on the store port. after
// reset the store is cleared one entry a cycle, during which no command is
// taken. the result sits in an output register: a stalled receiver does not
// block the next command, but the following result waits in the sequencer
// until the register frees.
module tile_image_transform_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  titr_cmd_if.sink   cmd_i,
  titr_res_if.source res_o
);
  localparam int AW = titr_pkg::AW;
  localparam int CW = titr_pkg::CW;
  localparam int LW = titr_pkg::LW;
  localparam int SW = titr_pkg::SW;

  titr_pkg::state_e state_q, state_d;
  titr_pkg::cmd_t   cmd_q, in_cmd;
  titr_pkg::pair_t  pair;

  logic [titr_pkg::PIXW-1:0] pix_q, pout_q, tmp_q;
  logic [CW-1:0]  rows_q, cols_q;
  logic [LW-1:0]  i_q, j_q, ilim_q, jlim_q, in_ilim, in_jlim;
  logic           end_q, ok_q, in_ok, loop_adv, last_i, last_j, accept, out_free;
  logic [AW:0]    k_q;
  logic [AW-1:0]  addr1_q, addr2_q, cpa_q, mpd_q;
  logic           cpv_q, mpv_q;
  logic           out_v_q, out_ok_q;
  logic [titr_pkg::PIXW-1:0] out_pix_q;
  logic [titr_pkg::CNTW-1:0] out_rows_q, out_cols_q;

  logic st_en, st_we, sc_en, sc_we;
  logic [AW-1:0] st_addr, sc_addr;
  logic [titr_pkg::PIXW-1:0] st_wd, st_rd, sc_wd, sc_rd;

  logic signed [SW-1:0] rs, m;
  logic sq;

  assign accept   = cmd_i.valid && cmd_i.ready;
  assign out_free = !out_v_q || res_o.ready;
  assign cmd_i.ready = (state_q == titr_pkg::S_IDLE);

  // incoming command, sign extended
  assign in_cmd.kind = titr_pkg::kind_e'(cmd_i.kind);
  assign in_cmd.a    = SW'(cmd_i.arg_a);
  assign in_cmd.b    = SW'(cmd_i.arg_b);
  assign in_cmd.c    = SW'(cmd_i.arg_c);
  assign in_cmd.d    = SW'(cmd_i.arg_d);

  assign rs = signed'(SW'(rows_q));
  assign sq = (rows_q == cols_q);
  assign m  = in_cmd.a[SW-1] ? -in_cmd.a : in_cmd.a;

  // argument check and loop bounds
  always_comb begin
    in_ok   = 1'b0;
    in_ilim = LW'(1);
    in_jlim = LW'(1);
    unique case (in_cmd.kind)
      titr_pkg::K_SIZE:
        in_ok = (in_cmd.a >= 0) && (in_cmd.a <= SW'(titr_pkg::DIM)) &&
                (in_cmd.b >= 0) && (in_cmd.b <= SW'(titr_pkg::DIM));
      titr_pkg::K_WRITE, titr_pkg::K_READ:
        in_ok = titr_pkg::cell_in(in_cmd.a, in_cmd.b, rows_q, cols_q);
      titr_pkg::K_SWAPCELL:
        in_ok = titr_pkg::cell_in(in_cmd.a, in_cmd.b, rows_q, cols_q) &&
                titr_pkg::cell_in(in_cmd.c, in_cmd.d, rows_q, cols_q);
      titr_pkg::K_SWAPNEIGH: begin
        in_ok   = titr_pkg::cell_in(in_cmd.a, in_cmd.b, rows_q, cols_q) &&
                  titr_pkg::cell_in(in_cmd.c, in_cmd.d, rows_q, cols_q);
        in_jlim = LW'(8);
      end
      titr_pkg::K_SWAPROWS: begin
        in_ok   = titr_pkg::cell_in(in_cmd.a, in_cmd.b, rows_q, rows_q);
        in_jlim = LW'(cols_q);
      end
      titr_pkg::K_SWAPCOLS: begin
        in_ok   = titr_pkg::cell_in(in_cmd.a, in_cmd.b, cols_q, cols_q);
        in_jlim = LW'(rows_q);
      end
      titr_pkg::K_SWAPDIAG: begin
        in_ok   = sq && (in_cmd.a >= 0) && (in_cmd.a < rs);
        in_jlim = LW'(rs - in_cmd.a);
      end
      titr_pkg::K_REVROW: begin
        in_ok   = (in_cmd.a >= 0) && (in_cmd.a < rs);
        in_jlim = LW'(cols_q >> 1);
      end
      titr_pkg::K_REVCOL: begin
        in_ok   = (in_cmd.a >= 0) && (in_cmd.a < signed'(SW'(cols_q)));
        in_jlim = LW'(rows_q >> 1);
      end
      titr_pkg::K_REVDIAG: begin
        in_ok   = sq && (m < rs);
        in_jlim = LW'((rs - m) >>> 1);
      end
      titr_pkg::K_MIRRORROWS: begin
        in_ok   = 1'b1;
        in_ilim = LW'(rows_q);
        in_jlim = LW'(cols_q >> 1);
      end
      titr_pkg::K_MIRRORCOLS: begin
        in_ok   = 1'b1;
        in_ilim = LW'(cols_q);
        in_jlim = LW'(rows_q >> 1);
      end
      titr_pkg::K_ROTATE: begin
        in_ok   = 1'b1;
        in_ilim = LW'(rows_q);
        in_jlim = LW'(cols_q);
      end
      titr_pkg::K_TRANSPOSE: begin
        in_ok   = sq;
        in_ilim = LW'(rows_q);
        in_jlim = LW'(rows_q);
      end
      default: in_ok = 1'b0;
    endcase
  end

  titr_pairgen u_pairgen (
    .cmd_i  (cmd_q),
    .rows_i (rows_q),
    .cols_i (cols_q),
    .i_i    (i_q),
    .j_i    (j_q),
    .pair_o (pair)
  );

  assign last_j = ({1'b0, j_q} + 1'b1) == {1'b0, jlim_q};
  assign last_i = ({1'b0, i_q} + 1'b1) == {1'b0, ilim_q};

  // sequencer: next state and memory port control
  always_comb begin
    state_d  = state_q;
    loop_adv = 1'b0;
    st_en = 1'b0; st_we = 1'b0; st_addr = '0; st_wd = '0;
    sc_en = 1'b0; sc_we = 1'b0; sc_addr = '0; sc_wd = '0;
    unique case (state_q)
      titr_pkg::S_CLEAR: begin
        st_en = 1'b1; st_we = 1'b1; st_addr = k_q[AW-1:0];
        if (k_q == (AW+1)'(titr_pkg::DEPTH - 1)) state_d = titr_pkg::S_IDLE;
      end
      titr_pkg::S_IDLE: begin
        if (cmd_i.valid) begin
          if (!in_ok) begin
            state_d = titr_pkg::S_DONE;
          end else begin
            unique case (in_cmd.kind)
              titr_pkg::K_SIZE:  state_d = titr_pkg::S_DONE;
              titr_pkg::K_WRITE: state_d = titr_pkg::S_PIXW;
              titr_pkg::K_READ:  state_d = titr_pkg::S_PIXR;
              titr_pkg::K_ROTATE, titr_pkg::K_TRANSPOSE: state_d = titr_pkg::S_CPY;
              default:           state_d = titr_pkg::S_GEN;
            endcase
          end
        end
      end
      titr_pkg::S_GEN: begin
        if (end_q) state_d = titr_pkg::S_DONE;
        else if (pair.do_pair) state_d = titr_pkg::S_RD1;
        else loop_adv = 1'b1;
      end
      titr_pkg::S_RD1: begin
        st_en = 1'b1; st_addr = addr1_q; state_d = titr_pkg::S_RD2;
      end
      titr_pkg::S_RD2: begin
        st_en = 1'b1; st_addr = addr2_q; state_d = titr_pkg::S_WR1;
      end
      titr_pkg::S_WR1: begin
        st_en = 1'b1; st_we = 1'b1; st_addr = addr1_q; st_wd = st_rd;
        state_d = titr_pkg::S_WR2;
      end
      titr_pkg::S_WR2: begin
        st_en = 1'b1; st_we = 1'b1; st_addr = addr2_q; st_wd = tmp_q;
        loop_adv = 1'b1;
        state_d  = titr_pkg::S_GEN;
      end
      titr_pkg::S_PIXW: begin
        st_en = 1'b1; st_we = 1'b1; st_addr = pair.addr1; st_wd = pix_q;
        state_d = titr_pkg::S_DONE;
      end
      titr_pkg::S_PIXR: begin
        st_en = 1'b1; st_addr = pair.addr1; state_d = titr_pkg::S_PIXL;
      end
      titr_pkg::S_PIXL: state_d = titr_pkg::S_DONE;
      // store to scratch copy, one entry a cycle
      titr_pkg::S_CPY: begin
        if (k_q < (AW+1)'(titr_pkg::DEPTH)) begin
          st_en = 1'b1; st_addr = k_q[AW-1:0];
        end
        if (cpv_q) begin
          sc_en = 1'b1; sc_we = 1'b1; sc_addr = cpa_q; sc_wd = st_rd;
        end
        if (k_q == (AW+1)'(titr_pkg::DEPTH) && !cpv_q) state_d = titr_pkg::S_MAP;
      end
      // scratch read at source, store write at destination in the next cycle
      titr_pkg::S_MAP: begin
        if (!end_q) begin
          sc_en = 1'b1; sc_addr = pair.addr1; loop_adv = 1'b1;
        end
        if (mpv_q) begin
          st_en = 1'b1; st_we = 1'b1; st_addr = mpd_q; st_wd = sc_rd;
        end
        if (end_q && !mpv_q) state_d = titr_pkg::S_DONE;
      end
      titr_pkg::S_DONE: begin
        if (out_free) state_d = titr_pkg::S_IDLE;
      end
      default: state_d = titr_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= titr_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      cpv_q  <= 1'b0;
      mpv_q  <= 1'b0;
      end_q  <= 1'b0;
      rows_q <= '0;
      cols_q <= '0;
    end else begin
      if (loop_adv && last_j && last_i) end_q <= 1'b1;
      unique case (state_q)
        titr_pkg::S_CLEAR: k_q <= k_q + 1'b1;
        titr_pkg::S_IDLE: begin
          if (accept) begin
            k_q   <= '0;
            end_q <= (in_ilim == '0) || (in_jlim == '0);
            if (in_ok && in_cmd.kind == titr_pkg::K_SIZE) begin
              rows_q <= CW'(in_cmd.a);
              cols_q <= CW'(in_cmd.b);
            end
          end
        end
        titr_pkg::S_CPY: begin
          if (k_q < (AW+1)'(titr_pkg::DEPTH)) begin
            cpv_q <= 1'b1;
            k_q   <= k_q + 1'b1;
          end else begin
            cpv_q <= 1'b0;
          end
        end
        titr_pkg::S_MAP: begin
          mpv_q <= !end_q;
          if (end_q && !mpv_q && cmd_q.kind == titr_pkg::K_ROTATE) begin
            rows_q <= cols_q;
            cols_q <= rows_q;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (loop_adv) begin
      if (last_j) begin
        j_q <= '0;
        if (!last_i) i_q <= i_q + 1'b1;
      end else begin
        j_q <= j_q + 1'b1;
      end
    end
    unique case (state_q)
      titr_pkg::S_IDLE: begin
        if (accept) begin
          cmd_q  <= in_cmd;
          pix_q  <= cmd_i.pixel_in;
          ok_q   <= in_ok;
          pout_q <= '0;
          i_q    <= '0;
          j_q    <= '0;
          ilim_q <= in_ilim;
          jlim_q <= in_jlim;
        end
      end
      titr_pkg::S_GEN: begin
        addr1_q <= pair.addr1;
        addr2_q <= pair.addr2;
      end
      titr_pkg::S_RD2:  tmp_q  <= st_rd;
      titr_pkg::S_PIXL: pout_q <= st_rd;
      titr_pkg::S_CPY:  cpa_q  <= k_q[AW-1:0];
      titr_pkg::S_MAP:  mpd_q  <= pair.addr2;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (state_q == titr_pkg::S_DONE && out_free) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == titr_pkg::S_DONE && out_free) begin
      out_ok_q   <= ok_q;
      out_pix_q  <= pout_q;
      out_rows_q <= titr_pkg::CNTW'(rows_q);
      out_cols_q <= titr_pkg::CNTW'(cols_q);
    end
  end

  assign res_o.valid     = out_v_q;
  assign res_o.ok        = out_ok_q;
  assign res_o.pixel_out = out_pix_q;
  assign res_o.row_count = out_rows_q;
  assign res_o.col_count = out_cols_q;

  titr_ram #(.Width(titr_pkg::PIXW), .Depth(titr_pkg::DEPTH)) u_store (
    .clk_i   (clk_i),
    .en_i    (st_en),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i (st_wd),
    .rdata_o (st_rd)
  );

  titr_ram #(.Width(titr_pkg::PIXW), .Depth(titr_pkg::DEPTH)) u_scratch (
    .clk_i   (clk_i),
    .en_i    (sc_en),
    .we_i    (sc_we),
    .addr_i  (sc_addr),
    .wdata_i (sc_wd),
    .rdata_o (sc_rd)
  );
endmodule

@@ hw/rtl/titr_checker.sv @@
// port-level checks of the image transform engine, bound to the top level
// depends on titr_pkg and tile_image_transform_engine_defines.svh
`include "tile_image_transform_engine_defines.svh"

module titr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cmd_valid_i,
  input logic                      cmd_ready_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic                      res_ok_i,
  input logic [titr_pkg::PIXW-1:0] res_pixel_out_i,
  input logic [titr_pkg::CNTW-1:0] res_row_count_i,
  input logic [titr_pkg::CNTW-1:0] res_col_count_i
);
  // a stalled result stays offered
  `TITR_ASSERT_NXT(res_hold_a, res_valid_i && !res_ready_i, res_valid_i)
  // a stalled result keeps its ok flag, pixel and row count
  `TITR_ASSERT_NXT(res_stable_a, res_valid_i && !res_ready_i,
    $stable(res_ok_i) && $stable(res_pixel_out_i) && $stable(res_row_count_i))
  // the block is busy right after taking a command
  `TITR_ASSERT_NXT(busy_after_cmd_a, cmd_valid_i && cmd_ready_i, !cmd_ready_i)
  // a rejected command carries no pixel and the column count stays in range
  `TITR_ASSERT(reject_clean_a, res_valid_i && !res_ok_i,
    (res_pixel_out_i == '0) && (res_col_count_i <= titr_pkg::CNTW'(titr_pkg::DIM)))
endmodule

bind tile_image_transform_engine titr_checker u_titr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cmd_valid_i     (cmd_i.valid),
  .cmd_ready_i     (cmd_i.ready),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_ok_i        (res_o.ok),
  .res_pixel_out_i (res_o.pixel_out),
  .res_row_count_i (res_o.row_count),
  .res_col_count_i (res_o.col_count)
);

@@ verif/titr_tb_if.sv @@
// testbench-side view of the command and result channels
// depends on titr_pkg; the rtl interfaces titr_cmd_if and titr_res_if are reused as they are
package titr_tb_types_pkg;
  import titr_pkg::*;

  // one command as the testbench holds it
  typedef struct {
    kind_e           kind;
    logic [KW-1:0]   raw_kind;
    logic signed [6:0] a;
    logic signed [6:0] b;
    logic signed [6:0] c;
    logic signed [6:0] d;
    logic [7:0]      pix;
  } tb_cmd_t;

  // one expected result
  typedef struct {
    logic       ok;
    logic [7:0] pix;
    logic [6:0] rows;
    logic [6:0] cols;
  } tb_res_t;
endpackage

@@ verif/tile_image_transform_engine_tb.sv @@
// self-checking testbench of the image transform engine
// depends on titr_pkg, titr_tb_types_pkg, titr_cmd_if, titr_res_if and the engine rtl
module tile_image_transform_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import titr_pkg::*;
  import titr_tb_types_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  titr_cmd_if cmd_if ();
  titr_res_if res_if ();

  tile_image_transform_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .res_o  (res_if.source)
  );

  always #5 clk_i = ~clk_i;

  // shadow image state
  logic [7:0] img [DIM*DIM];
  int         img_rows;
  int         img_cols;

  tb_cmd_t cmd_pending [$];
  tb_res_t res_expected [$];
  int      n_err;
  int      cycle_cnt;
  bit      all_sent;
  bit      hold_sender;

  function automatic bit in_img(int r, int c);
    return r >= 0 && r < img_rows && c >= 0 && c < img_cols;
  endfunction

  function automatic void swap_px(int r1, int c1, int r2, int c2);
    logic [7:0] t;
    if (!in_img(r1, c1) || !in_img(r2, c2)) return;
    t = img[r1*DIM+c1];
    img[r1*DIM+c1] = img[r2*DIM+c2];
    img[r2*DIM+c2] = t;
  endfunction

  function automatic void flip_row(int r);
    for (int i = 0; i < img_cols/2; i++) swap_px(r, i, r, img_cols-1-i);
  endfunction

  function automatic void flip_col(int c);
    for (int i = 0; i < img_rows/2; i++) swap_px(i, c, img_rows-1-i, c);
  endfunction

  // predict the result of one command and update the shadow image
  function automatic tb_res_t apply_transform(tb_cmd_t t);
    tb_res_t    res;
    logic [7:0] snap [DIM*DIM];
    int a, b, c, d, n, m, r0, c0;
    bit sq;
    a = t.a; b = t.b; c = t.c; d = t.d;
    n = img_rows;
    sq = img_rows == img_cols;
    res.ok = 1'b0;
    res.pix = '0;
    case (t.raw_kind)
      K_SIZE: if (a >= 0 && a <= DIM && b >= 0 && b <= DIM) begin
        img_rows = a; img_cols = b; res.ok = 1'b1;
      end
      K_WRITE: if (in_img(a, b)) begin
        img[a*DIM+b] = t.pix; res.ok = 1'b1;
      end
      K_READ: if (in_img(a, b)) begin
        res.pix = img[a*DIM+b]; res.ok = 1'b1;
      end
      K_SWAPCELL: if (in_img(a, b) && in_img(c, d)) begin
        swap_px(a, b, c, d); res.ok = 1'b1;
      end
      K_SWAPROWS: if (a >= 0 && a < img_rows && b >= 0 && b < img_rows) begin
        for (int i = 0; i < img_cols; i++) swap_px(a, i, b, i);
        res.ok = 1'b1;
      end
      K_SWAPCOLS: if (a >= 0 && a < img_cols && b >= 0 && b < img_cols) begin
        for (int i = 0; i < img_rows; i++) swap_px(i, a, i, b);
        res.ok = 1'b1;
      end
      K_SWAPDIAG: if (sq && a >= 0 && a < n) begin
        for (int i = 0; i < n-a; i++) swap_px(a+i, i, i, a+i);
        res.ok = 1'b1;
      end
      K_REVROW: if (a >= 0 && a < img_rows) begin
        flip_row(a); res.ok = 1'b1;
      end
      K_REVCOL: if (a >= 0 && a < img_cols) begin
        flip_col(a); res.ok = 1'b1;
      end
      K_REVDIAG: begin
        m = (a < 0) ? -a : a;
        if (sq && m < n) begin
          for (int i = 0; i < (n-m)/2; i++)
            if (a >= 0) swap_px(i, m+i, n-1-i-m, n-1-i);
            else swap_px(m+i, i, n-1-i, n-1-i-m);
          res.ok = 1'b1;
        end
      end
      K_MIRRORROWS: begin
        for (int i = 0; i < img_rows; i++) flip_row(i);
        res.ok = 1'b1;
      end
      K_MIRRORCOLS: begin
        for (int i = 0; i < img_cols; i++) flip_col(i);
        res.ok = 1'b1;
      end
      K_ROTATE: begin
        r0 = img_rows; c0 = img_cols;
        snap = img;
        for (int i = 0; i < r0; i++)
          for (int j = 0; j < c0; j++) img[j*DIM + (r0-1-i)] = snap[i*DIM+j];
        img_rows = c0; img_cols = r0; res.ok = 1'b1;
      end
      K_SWAPNEIGH: if (in_img(a, b) && in_img(c, d)) begin
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) swap_px(a+dr, b+dc, c+dr, d+dc);
        res.ok = 1'b1;
      end
      K_TRANSPOSE: if (sq) begin
        snap = img;
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) img[i*DIM+j] = snap[j*DIM+i];
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.rows = 7'(img_rows);
    res.cols = 7'(img_cols);
    return res;
  endfunction

  function automatic tb_cmd_t make_cmd(logic [3:0] k, int a, int b, int c, int d, int p);
    tb_cmd_t t;
    t.raw_kind = k;
    t.kind = kind_e'(k);
    t.a = 7'(a); t.b = 7'(b); t.c = 7'(c); t.d = 7'(d);
    t.pix = 8'(p);
    return t;
  endfunction

  // random argument: mostly in 0..lim-1, sometimes in lim..lim+2 or anywhere in -64..63
  function automatic int pick_idx(int lim);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 127) - 64;
    if (r == 1) return lim + $urandom_range(0, 2);
    if (lim <= 0) return 0;
    return $urandom_range(0, lim-1);
  endfunction

  // sender: bursts of transfers with random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_if.valid && cmd_if.ready)
          res_expected.push_back(apply_transform(cmd_pending.pop_front()));
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          cmd_if.valid <= 1'b0;
        end else if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          cmd_if.valid <= 1'b0;
        end else if (cmd_pending.size() != 0 && !hold_sender) begin
          burst_left <= burst_left - 1;
          cmd_if.valid <= 1'b1;
          cmd_if.kind <= cmd_pending[0].raw_kind;
          cmd_if.arg_a <= cmd_pending[0].a;
          cmd_if.arg_b <= cmd_pending[0].b;
          cmd_if.arg_c <= cmd_pending[0].c;
          cmd_if.arg_d <= cmd_pending[0].d;
          cmd_if.pixel_in <= cmd_pending[0].pix;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern and result check
  logic [7:0] stall_pat;
  tb_res_t    want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_pat <= 8'b1011_0111;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (res_expected.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result transfer at cycle %0d", cycle_cnt);
        end else begin
          want = res_expected.pop_front();
          if (res_if.ok !== want.ok || res_if.pixel_out !== want.pix ||
              res_if.row_count !== want.rows || res_if.col_count !== want.cols) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: exp ok=%0d pix=%0d r=%0d c=%0d got ok=%0d pix=%0d r=%0d c=%0d",
                       want.ok, want.pix, want.rows, want.cols, res_if.ok,
                       res_if.pixel_out, res_if.row_count, res_if.col_count);
          end
        end
      end
      stall_pat <= {stall_pat[6:0], stall_pat[7] ^ stall_pat[5] ^ stall_pat[4] ^ stall_pat[3]};
      res_if.ready <= (cycle_cnt % 2000 < 1000) ? 1'b1 : stall_pat[0];
    end
  end

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 5000000) begin
      $display("tile_image_transform_engine_tb: errors");
      $finish;
    end
  end

  initial begin
    int k;
    n_err = 0;
    cycle_cnt = 0;
    hold_sender = 1'b0;
    img_rows = 0;
    img_cols = 0;
    for (int i = 0; i < DIM*DIM; i++) img[i] = '0;
    cmd_if.valid = 1'b0;
    cmd_if.kind = '0;
    cmd_if.arg_a = '0;
    cmd_if.arg_b = '0;
    cmd_if.arg_c = '0;
    cmd_if.arg_d = '0;
    cmd_if.pixel_in = '0;
    res_if.ready = 1'b0;

    // directed: size limits, each command, diagonal signs, edge neighbours
    cmd_pending.push_back(make_cmd(K_READ, 0, 0, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_SIZE, 33, 4, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_SIZE, -1, 4, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_SIZE, DIM, DIM, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_WRITE, 31, 31, 0, 0, 255));
    cmd_pending.push_back(make_cmd(K_WRITE, 0, 0, 0, 0, 170));
    cmd_pending.push_back(make_cmd(K_WRITE, 0, 1, 0, 0, 85));
    cmd_pending.push_back(make_cmd(K_ROTATE, 0, 0, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_TRANSPOSE, 0, 0, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_SIZE, 4, 4, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_SWAPCELL, 0, 0, 3, 3, 0));
    cmd_pending.push_back(make_cmd(K_SWAPROWS, 0, 3, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_SWAPCOLS, 1, 3, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_SWAPDIAG, 1, 0, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_REVROW, 3, 0, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_REVCOL, 0, 0, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_REVDIAG, 1, 0, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_REVDIAG, -1, 0, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_MIRRORROWS, 0, 0, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_MIRRORCOLS, 0, 0, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_SWAPNEIGH, 0, 0, 3, 3, 0));
    cmd_pending.push_back(make_cmd(4'd15, 63, -64, 63, -64, 0));
    cmd_pending.push_back(make_cmd(K_SIZE, 3, 5, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_TRANSPOSE, 0, 0, 0, 0, 0));
    cmd_pending.push_back(make_cmd(K_ROTATE, 0, 0, 0, 0, 0));

    // release reset before the sender has to drain anything
    repeat (8) @(posedge clk_i);
    rst_ni = 1'b1;

    // random: small images, mostly in-range arguments
    for (int i = 0; i < 220; i++) begin
      int r, c;
      if (i % 40 == 0) begin
        r = ($urandom_range(0, 9) == 0) ? DIM : $urandom_range(1, 8);
        c = ($urandom_range(0, 3) == 0) ? r : $urandom_range(1, 8);
        cmd_pending.push_back(make_cmd(K_SIZE, r, c, 0, 0, 0));
        for (int w = 0; w < 6; w++)
          cmd_pending.push_back(make_cmd(K_WRITE, $urandom_range(0, r-1),
                                         $urandom_range(0, c-1), 0, 0, $urandom_range(0, 255)));
      end
      k = $urandom_range(0, 15);
      if (k == K_SIZE && $urandom_range(0, 1)) k = K_READ;
      if (k == K_SIZE)
        cmd_pending.push_back(make_cmd(K_SIZE, $urandom_range(0, 127) - 64,
                                       $urandom_range(0, 127) - 64, $urandom_range(0, 127) - 64,
                                       $urandom_range(0, 127) - 64, $urandom_range(0, 255)));
      else
        cmd_pending.push_back(make_cmd(4'(k), (k == K_REVDIAG && $urandom_range(0, 1)) ?
                                       -pick_idx(8) : pick_idx(8), pick_idx(8), pick_idx(8),
                                       pick_idx(8), $urandom_range(0, 255)));
      // one pause of the sender until everything drained
      if (i == 130) begin
        wait (cmd_pending.size() == 0);
        hold_sender = 1'b1;
        wait (res_expected.size() == 0 && !cmd_if.valid);
        hold_sender = 1'b0;
      end
    end

    wait (cmd_pending.size() == 0 && !cmd_if.valid);
    wait (res_expected.size() == 0);
    repeat (3000) @(posedge clk_i);
    if (n_err == 0)
      $display("tile_image_transform_engine_tb: clean");
    else
      $display("tile_image_transform_engine_tb: errors");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/titr_pkg.sv
hw/rtl/titr_cmd_if.sv
hw/rtl/titr_res_if.sv
hw/rtl/titr_ram.sv
hw/rtl/titr_pairgen.sv
hw/rtl/tile_image_transform_engine.sv
hw/rtl/titr_checker.sv
verif/titr_tb_if.sv
verif/tile_image_transform_engine_tb.sv
